/* src/ksrt_pkg.sv */
// shared types and constants of the keyed source rate table
package ksrt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int CELL_W  = 12;
  localparam int COMP_W  = 3;
  localparam int KEY_W   = 3 * CELL_W + COMP_W;
  localparam int VAL_W   = 64;
  localparam int ENTRY_W = KEY_W + 2 * VAL_W;

  // exact heat-rate sum over a full table
  localparam int ACC_W = VAL_W + IDX_W + 1;

  // stream packing
  localparam int S_DATA_W = ((ENTRY_W + 7) / 8) * 8;
  localparam int M_DATA_W = 2 * VAL_W;
  localparam int FUNC_W   = 2;
  localparam int M_USER_W = 8;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_UPSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUM    = 2'd2;

  // saturation limits
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // request from the sequencer to the entry memory
  typedef struct packed {
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
  } ram_req_t;

  // one decoded input transaction
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  rate;
    logic [VAL_W-1:0]  heat;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [VAL_W-1:0] rate_result;
    logic [VAL_W-1:0] heat_rate_total;
    logic             key_matched;
    logic             dropped_full;
    logic             sum_saturated;
  } result_t;

endpackage

/* src/ksrt_ram.sv */
// generic single-port-write, single-port-read synchronous ram
module ksrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/ksrt_ctrl.sv */
// scan sequencer: walks the entry memory, matches keys, sums heat rates
module ksrt_ctrl
  import ksrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  item_t              in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output result_t            out_res,
  output ram_req_t           ram_req,
  input  logic [ENTRY_W-1:0] ram_rd_data
);

  state_t state, state_next;

  // captured transaction and table fill
  item_t            item;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] ptr;

  // compare stage
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic [VAL_W-1:0] found_rate;
  logic             any_cell;
  logic [ACC_W-1:0] acc;

  logic               issue_rd;
  logic               fin_go;
  logic [KEY_W-1:0]   d_key;
  logic [VAL_W-1:0]   d_rate;
  logic [VAL_W-1:0]   d_heat;
  logic               table_full;
  logic [ACC_W-VAL_W:0] acc_top;
  logic               acc_fits;
  result_t            res_next;

  assign d_key      = ram_rd_data[KEY_W-1:0];
  assign d_rate     = ram_rd_data[KEY_W +: VAL_W];
  assign d_heat     = ram_rd_data[KEY_W+VAL_W +: VAL_W];
  assign table_full = (entry_count == CNT_W'(TABLE_DEPTH));
  assign acc_top    = acc[ACC_W-1:VAL_W-1];
  assign acc_fits   = (&acc_top) || !(|acc_top);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (ptr == entry_count && !rd_vld) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
    issue_rd = (state == ST_SCAN) && (ptr != entry_count);
    fin_go   = (state == ST_FINISH) && (!out_valid || out_ready);

    ram_req.rd_en   = issue_rd;
    ram_req.rd_addr = ptr[IDX_W-1:0];
    ram_req.wr_en   = fin_go && (item.func == FUNC_UPSERT) && (found || !table_full);
    ram_req.wr_addr = found ? found_idx : entry_count[IDX_W-1:0];
    ram_req.wr_data = {item.heat, item.rate, item.key};
  end

  // result of the finished scan
  always_comb begin
    res_next = '0;
    unique case (item.func)
      FUNC_UPSERT: begin
        res_next.key_matched  = found;
        res_next.dropped_full = !found && table_full;
      end
      FUNC_LOOKUP: begin
        res_next.key_matched = found;
        res_next.rate_result = found ? found_rate : '0;
      end
      FUNC_SUM: begin
        res_next.key_matched   = any_cell;
        res_next.sum_saturated = !acc_fits;
        if (acc_fits) begin
          res_next.heat_rate_total = acc[VAL_W-1:0];
        end else if (acc[ACC_W-1]) begin
          res_next.heat_rate_total = VAL_MIN;
        end else begin
          res_next.heat_rate_total = VAL_MAX;
        end
      end
      default: res_next = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
      rd_vld      <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue_rd;
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fin_go && item.func == FUNC_UPSERT && !found && !table_full) begin
        entry_count <= entry_count + CNT_W'(1);
      end
    end
  end

  // capture, scan pointer and compare stage
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item     <= in_item;
      ptr      <= '0;
      found    <= 1'b0;
      any_cell <= 1'b0;
      acc      <= '0;
    end else begin
      if (issue_rd) begin
        ptr    <= ptr + CNT_W'(1);
        rd_idx <= ptr[IDX_W-1:0];
      end
      if (rd_vld) begin
        // first matching key wins
        if (!found && d_key == item.key) begin
          found      <= 1'b1;
          found_idx  <= rd_idx;
          found_rate <= d_rate;
        end
        // any component at the cell contributes to the sum
        if (d_key[KEY_W-1:COMP_W] == item.key[KEY_W-1:COMP_W]) begin
          any_cell <= 1'b1;
          acc      <= acc + {{(ACC_W-VAL_W){d_heat[VAL_W-1]}}, d_heat};
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_res <= res_next;
    end
  end

endmodule

/* src/keyed_source_rate_table_top.sv */
// top level of the keyed source rate table with stream ports
//
// Input channel (s_*): one transaction is one operation. s_tuser carries the
// operation code: upsert an entry, look up the rate of a key, or sum the heat
// rates of every entry at a cell. s_tdata carries the cell coordinate, the
// component code and the rate and heat rate for an upsert.
// Output channel (m_*): exactly one result transaction per operation, in order.
// With n stored entries an operation scans all n of them: the sequencer reads
// one entry a cycle from the entry memory, whose single registered read port
// sets the scan length. A new operation is accepted only after the sequencer
// has finished the previous one; its result is written to the output register
// once its scan has ended and the register is free.
// The output register holds a result while the receiver stalls; the next
// operation is accepted and scanned meanwhile, and waits at its end until the
// register is free.
// Reset clears the entry count, so the table starts empty; no clearing pass
// over the memory is needed.
module keyed_source_rate_table_top
  import ksrt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // cell_i, cell_j, cell_k, component_code, rate_value, heat_rate_value, pad
  input  logic [S_DATA_W-1:0] s_tdata,
  // func
  input  logic [FUNC_W-1:0]   s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // rate_result, heat_rate_total
  output logic [M_DATA_W-1:0] m_tdata,
  // key_matched, dropped_full, sum_saturated, pad
  output logic [M_USER_W-1:0] m_tuser
);

  item_t              item;
  result_t            res;
  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rd_data;
  logic [CELL_W-1:0]  cell_i;
  logic [CELL_W-1:0]  cell_j;
  logic [CELL_W-1:0]  cell_k;
  logic [COMP_W-1:0]  component_code;

  // unpack the input transaction into a key and values
  assign cell_i         = s_tdata[0 +: CELL_W];
  assign cell_j         = s_tdata[CELL_W +: CELL_W];
  assign cell_k         = s_tdata[2*CELL_W +: CELL_W];
  assign component_code = s_tdata[3*CELL_W +: COMP_W];
  assign item.func      = s_tuser;
  assign item.key       = {cell_i, cell_j, cell_k, component_code};
  assign item.rate      = s_tdata[KEY_W +: VAL_W];
  assign item.heat      = s_tdata[KEY_W+VAL_W +: VAL_W];

  // pack the result transaction
  assign m_tdata = {res.heat_rate_total, res.rate_result};
  assign m_tuser = {{(M_USER_W-3){1'b0}}, res.sum_saturated, res.dropped_full,
                    res.key_matched};

  ksrt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_item     (item),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_res     (res),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  ksrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
